### sv/sdaq_pkg.sv
// shared types and codes for the sorted deadline alarm queue
package sdaq_pkg;

  localparam int unsigned DEPTH_DEF = 16;

  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

  // action codes of an input transfer
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_SET   = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;
  localparam logic [1:0] ACT_POP   = 2'd3;

  // status codes of a result transfer
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ROTATE
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e   cmd;
    logic [31:0] deadline;
  } cell_ctrl_t;

endpackage

### sv/sorted_deadline_alarm_queue_top.sv
// top level of the sorted deadline alarm queue: control, counter and cell chain
// result strobe: in the cycle after the accepting edge for clear, pop and a quiet tick;
// for a set and a firing tick after the re-arm walk over the cell ring, through S_SCAN, then S_DONE
// transfers: one at a time, busy until the strobe ends, so no new transfer is taken before
// the last one is through; the receiver cannot stall
// reset: asynchronous active low, clears counter, count and alarm; slots are not cleared
module sorted_deadline_alarm_queue_top #(
  parameter int unsigned DEPTH = sdaq_pkg::DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [15:0] seconds_i,
  output logic        result_valid_o,
  output logic        fired_o,
  output logic        armed_o,
  output logic [31:0] armed_deadline_o,
  output logic [31:0] remaining_o,
  output logic [31:0] current_time_o,
  output logic [4:0]  entries_o,
  output logic [31:0] earliest_o,
  output logic [31:0] popped_value_o,
  output logic [1:0]  status_o
);
  import sdaq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW = $clog2(DEPTH);

  // controller states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [31:0]     now_q, now_d;
  logic            armed_q, armed_d;
  logic [31:0]     pending_q, pending_d;
  logic            fired_q, fired_d;
  logic [31:0]     popped_q, popped_d;
  logic [1:0]      status_q, status_d;
  logic [IdxW-1:0] idx_q, idx_d;

  logic [DEPTH-1:0][31:0] cell_val;
  logic [DEPTH-1:0]       cell_le;
  logic [DEPTH-1:0]       occ;
  cell_ctrl_t             ctrl;

  logic        accept;
  logic [31:0] now_inc;
  logic [32:0] set_sum;
  logic [31:0] set_deadline;
  logic        full;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // saturating counter step and saturating deadline sum
  assign now_inc      = (now_q == TIME_MAX) ? now_q : now_q + 32'd1;
  assign set_sum      = {1'b0, now_q} + 33'(seconds_i);
  assign set_deadline = set_sum[32] ? TIME_MAX : set_sum[31:0];
  assign full         = (count_q >= CntW'(DEPTH));

  // chain command: sorted insert on a set when not full, rotate on a pop when not empty and during the walk
  always_comb begin
    ctrl.cmd      = CELL_HOLD;
    ctrl.deadline = set_deadline;
    if (accept && (action_i == ACT_SET) && !full) begin
      ctrl.cmd = CELL_INSERT;
    end else if (accept && (action_i == ACT_POP) && (count_q != '0)) begin
      ctrl.cmd = CELL_ROTATE;
    end else if (state_q == S_SCAN) begin
      ctrl.cmd = CELL_ROTATE;
    end
  end

  // ring of cells: each takes its left neighbor on insert, its right one on rotate
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int unsigned Prev = (i == 0) ? DEPTH - 1 : i - 1;
    localparam int unsigned Next = (i == DEPTH - 1) ? 0 : i + 1;

    assign occ[i] = (CntW'(i) < count_q);

    sdaq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occ_i      (occ[i]),
      .prev_val_i (cell_val[Prev]),
      // head slot has no left neighbor: it takes the new deadline if it moves
      .prev_le_i  ((i == 0) ? 1'b1 : cell_le[Prev]),
      .next_val_i (cell_val[Next]),
      .val_o      (cell_val[i]),
      .le_o       (cell_le[i])
    );
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    now_d     = now_q;
    armed_d   = armed_q;
    pending_d = pending_q;
    fired_d   = fired_q;
    popped_d  = popped_q;
    status_d  = status_q;
    idx_d     = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          fired_d  = 1'b0;
          popped_d = '0;
          status_d = ST_OK;
          idx_d    = '0;
          state_d  = S_DONE;
          unique case (action_i)
            ACT_TICK: begin
              now_d = now_inc;
              if (armed_q && (pending_q <= now_inc)) begin
                fired_d   = 1'b1;
                armed_d   = 1'b0;
                pending_d = '0;
                state_d   = S_SCAN;
              end
            end
            ACT_SET: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                count_d = count_q + CntW'(1);
              end
              armed_d   = 1'b0;
              pending_d = '0;
              state_d   = S_SCAN;
            end
            ACT_CLEAR: begin
              armed_d   = 1'b0;
              pending_d = '0;
            end
            ACT_POP: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                popped_d = cell_val[0];
                count_d  = count_q - CntW'(1);
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        // head slot holds entry idx_q; first one later than now wins
        if (!armed_q && (CntW'(idx_q) < count_q) && (cell_val[0] > now_q)) begin
          armed_d   = 1'b1;
          pending_d = cell_val[0];
        end
        idx_d = idx_q + IdxW'(1);
        if (idx_q == IdxW'(DEPTH - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      now_q     <= '0;
      armed_q   <= 1'b0;
      pending_q <= '0;
      fired_q   <= 1'b0;
      popped_q  <= '0;
      status_q  <= ST_OK;
      idx_q     <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      now_q     <= now_d;
      armed_q   <= armed_d;
      pending_q <= pending_d;
      fired_q   <= fired_d;
      popped_q  <= popped_d;
      status_q  <= status_d;
      idx_q     <= idx_d;
    end
  end

  // result fields come straight from state registers; ring is back in order here
  assign result_valid_o   = (state_q == S_DONE);
  assign fired_o          = fired_q;
  assign armed_o          = armed_q;
  assign armed_deadline_o = armed_q ? pending_q : '0;
  assign remaining_o      = (armed_q && (pending_q > now_q)) ? pending_q - now_q : '0;
  assign current_time_o   = now_q;
  assign entries_o        = 5'(count_q);
  assign earliest_o       = (count_q != '0) ? cell_val[0] : '0;
  assign popped_value_o   = popped_q;
  assign status_o         = status_q;

`ifndef ASSERT_OFF
  // an accepted transfer makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted transfer did not raise busy");

  // a result strobe lasts one cycle and is followed by idle
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> (!result_valid_o && !busy))
    else $error("result strobe longer than one cycle");

  // at a result strobe, a pending alarm lies strictly in the future
  a_armed_future: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && armed_o) |-> (remaining_o != 32'd0))
    else $error("armed alarm not later than current time");

  // the count never exceeds the number of slots
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count beyond depth");
`endif

endmodule

### sv/sdaq_cell.sv
// one slot of the sorted deadline chain
module sdaq_cell (
  input  logic                clk_i,
  input  sdaq_pkg::cell_ctrl_t ctrl_i,
  input  logic                occ_i,
  input  logic [31:0]         prev_val_i,
  input  logic                prev_le_i,
  input  logic [31:0]         next_val_i,
  output logic [31:0]         val_o,
  output logic                le_o
);
  import sdaq_pkg::*;

  logic [31:0] val_q, val_d;

  // occupied and not later than the new deadline: stays put on insert
  assign le_o = occ_i && (val_q <= ctrl_i.deadline);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    case (ctrl_i.cmd)
      CELL_INSERT: begin
        if (le_o) begin
          val_d = val_q;
        end else if (prev_le_i) begin
          val_d = ctrl_i.deadline;
        end else begin
          val_d = prev_val_i;
        end
      end
      CELL_ROTATE: val_d = next_val_i;
      default:     val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule
